@@ design/bsh_pkg.sv @@
// shared types and constants for the operand2 barrel shifter
package bsh_pkg;

    localparam int unsigned DATA_W    = 32;
    localparam int unsigned OP2_W     = 12;
    localparam int unsigned RS_W      = 8;
    localparam int unsigned AMT_W     = 5;
    localparam int unsigned IMM_W     = 8;

    // op2_field layout
    localparam int unsigned ROT_LSB   = 8;
    localparam int unsigned ROT_MSB   = 11;
    localparam int unsigned AMT_LSB   = 7;
    localparam int unsigned AMT_MSB   = 11;
    localparam int unsigned TYPE_LSB  = 5;
    localparam int unsigned TYPE_MSB  = 6;
    localparam int unsigned BY_REG_BIT = 4;

    localparam logic [RS_W-1:0] FULL_WORD = RS_W'(DATA_W);

    typedef enum logic [1:0] {
        SHIFT_LSL = 2'd0,
        SHIFT_LSR = 2'd1,
        SHIFT_ASR = 2'd2,
        SHIFT_ROR = 2'd3
    } shift_type_t;

endpackage

@@ design/bsh_if.sv @@
// request and result channel interfaces of the operand2 barrel shifter
interface bsh_req_if;
    logic                         valid;
    logic                         ready;
    logic                         imm_flag;
    logic                         set_flag;
    logic                         is_data_proc;
    logic [bsh_pkg::OP2_W-1:0]    op2_field;
    logic [bsh_pkg::DATA_W-1:0]   rm_value;
    logic [bsh_pkg::RS_W-1:0]     rs_low_byte;
    logic                         carry_in;

    modport source (
        output valid, imm_flag, set_flag, is_data_proc, op2_field, rm_value,
               rs_low_byte, carry_in,
        input  ready
    );
    modport sink (
        input  valid, imm_flag, set_flag, is_data_proc, op2_field, rm_value,
               rs_low_byte, carry_in,
        output ready
    );
    modport mon (
        input  valid, ready, imm_flag, set_flag, is_data_proc, op2_field,
               rm_value, rs_low_byte, carry_in
    );
endinterface

interface bsh_rsp_if;
    logic                         valid;
    logic                         ready;
    logic [bsh_pkg::DATA_W-1:0]   operand_value;
    logic                         carry_write;
    logic                         carry_value;

    modport source (
        output valid, operand_value, carry_write, carry_value,
        input  ready
    );
    modport sink (
        input  valid, operand_value, carry_write, carry_value,
        output ready
    );
    modport mon (
        input  valid, ready, operand_value, carry_write, carry_value
    );
endinterface

@@ design/operand2_barrel_shifter_top.sv @@
// operand2 barrel shifter: input register, shift logic, result register
// path: an accepted request is held in the input register, and its result is then held in the result register
// throughput: one request per cycle while results are taken, set by the single shift pass between the registers
// the request side stays ready while a result waits, until both registers are full
// reset: asynchronous active-low rst_n empties both registers; no other state
module operand2_barrel_shifter_top (
    input  logic           clk,
    input  logic           rst_n,
    bsh_req_if.sink        req,
    bsh_rsp_if.source      rsp
);

    logic                         s1_valid_reg;
    logic                         s1_imm_reg;
    logic                         s1_set_reg;
    logic                         s1_dp_reg;
    logic [bsh_pkg::OP2_W-1:0]    s1_op2_reg;
    logic [bsh_pkg::DATA_W-1:0]   s1_rm_reg;
    logic [bsh_pkg::RS_W-1:0]     s1_rs_reg;
    logic                         s1_cin_reg;

    logic                         rsp_valid_reg;
    logic [bsh_pkg::DATA_W-1:0]   rsp_value_reg;
    logic                         rsp_cwr_reg;
    logic                         rsp_cval_reg;

    logic                         s2_load;
    logic                         s1_load;

    logic [bsh_pkg::DATA_W-1:0]   value_next;
    logic                         cwr_next;
    logic                         cval_next;

    logic                         by_reg;
    bsh_pkg::shift_type_t         shift_op;
    logic [bsh_pkg::RS_W-1:0]     amount;
    logic [bsh_pkg::AMT_W-1:0]    amt_lo;
    logic                         amt_big;
    logic [2*bsh_pkg::DATA_W-1:0] rot_wide;
    logic [bsh_pkg::DATA_W:0]     lsl_wide;
    logic [bsh_pkg::DATA_W:0]     lsr_wide;
    logic [bsh_pkg::DATA_W:0]     asr_wide;
    logic [bsh_pkg::AMT_W-1:0]    imm_rot;
    logic [2*bsh_pkg::DATA_W-1:0] imm_wide;
    logic [bsh_pkg::DATA_W-1:0]   imm_word;
    logic                         sign;

    assign s2_load   = !rsp_valid_reg || rsp.ready;
    assign s1_load   = !s1_valid_reg || s2_load;
    assign req.ready = s1_load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_load)
            begin
                s1_valid_reg <= req.valid;
            end
            if (s2_load)
            begin
                rsp_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_load && req.valid)
        begin
            s1_imm_reg <= req.imm_flag;
            s1_set_reg <= req.set_flag;
            s1_dp_reg  <= req.is_data_proc;
            s1_op2_reg <= req.op2_field;
            s1_rm_reg  <= req.rm_value;
            s1_rs_reg  <= req.rs_low_byte;
            s1_cin_reg <= req.carry_in;
        end
        if (s2_load && s1_valid_reg)
        begin
            rsp_value_reg <= value_next;
            rsp_cwr_reg   <= cwr_next;
            rsp_cval_reg  <= cval_next;
        end
    end

    always_comb
    begin
        by_reg   = s1_op2_reg[bsh_pkg::BY_REG_BIT];
        shift_op = bsh_pkg::shift_type_t'(s1_op2_reg[bsh_pkg::TYPE_MSB:bsh_pkg::TYPE_LSB]);
        sign     = s1_rm_reg[bsh_pkg::DATA_W-1];

        amount = by_reg ? s1_rs_reg
                        : bsh_pkg::RS_W'(s1_op2_reg[bsh_pkg::AMT_MSB:bsh_pkg::AMT_LSB]);
        // immediate-field zero on LSR/ASR encodes a full-word shift
        if (!by_reg && amount == '0
            && (shift_op == bsh_pkg::SHIFT_LSR || shift_op == bsh_pkg::SHIFT_ASR))
        begin
            amount = bsh_pkg::FULL_WORD;
        end
        amt_lo  = amount[bsh_pkg::AMT_W-1:0];
        amt_big = (amount[bsh_pkg::RS_W-1:bsh_pkg::AMT_W] != '0);

        // carry sits in the extra bit of each widened LSL, LSR and ASR shift
        lsl_wide = {1'b0, s1_rm_reg} << amt_lo;
        lsr_wide = {s1_rm_reg, 1'b0} >> amt_lo;
        asr_wide = (bsh_pkg::DATA_W + 1)'($signed({s1_rm_reg, 1'b0}) >>> amt_lo);
        rot_wide = {s1_rm_reg, s1_rm_reg} >> amt_lo;

        imm_rot  = {s1_op2_reg[bsh_pkg::ROT_MSB:bsh_pkg::ROT_LSB], 1'b0};
        imm_word = bsh_pkg::DATA_W'(s1_op2_reg[bsh_pkg::IMM_W-1:0]);
        imm_wide = {imm_word, imm_word} >> imm_rot;

        value_next = s1_rm_reg;
        cval_next  = s1_cin_reg;
        cwr_next   = 1'b0;

        if (s1_imm_reg)
        begin
            value_next = imm_wide[bsh_pkg::DATA_W-1:0];
        end
        else
        begin
            cwr_next = s1_set_reg && s1_dp_reg;
            if (amount != '0)
            begin
                unique case (shift_op)
                    bsh_pkg::SHIFT_LSL:
                    begin
                        if (!amt_big)
                        begin
                            value_next = lsl_wide[bsh_pkg::DATA_W-1:0];
                            cval_next  = lsl_wide[bsh_pkg::DATA_W];
                        end
                        else
                        begin
                            value_next = '0;
                            cval_next  = (amount == bsh_pkg::FULL_WORD) && s1_rm_reg[0];
                        end
                    end
                    bsh_pkg::SHIFT_LSR:
                    begin
                        if (!amt_big)
                        begin
                            value_next = lsr_wide[bsh_pkg::DATA_W:1];
                            cval_next  = lsr_wide[0];
                        end
                        else
                        begin
                            value_next = '0;
                            cval_next  = (amount == bsh_pkg::FULL_WORD) && sign;
                        end
                    end
                    bsh_pkg::SHIFT_ASR:
                    begin
                        if (!amt_big)
                        begin
                            value_next = asr_wide[bsh_pkg::DATA_W:1];
                            cval_next  = asr_wide[0];
                        end
                        else
                        begin
                            value_next = {bsh_pkg::DATA_W{sign}};
                            cval_next  = sign;
                        end
                    end
                    bsh_pkg::SHIFT_ROR:
                    begin
                        // rotation is modulo the word; carry is the new top bit
                        value_next = rot_wide[bsh_pkg::DATA_W-1:0];
                        cval_next  = rot_wide[bsh_pkg::DATA_W-1];
                    end
                    default:
                    begin
                        value_next = s1_rm_reg;
                    end
                endcase
            end
        end
    end

    assign rsp.valid         = rsp_valid_reg;
    assign rsp.operand_value = rsp_value_reg;
    assign rsp.carry_write   = rsp_cwr_reg;
    assign rsp.carry_value   = rsp_cval_reg;

endmodule

@@ design/bsh_checker.sv @@
// port-level checker for the operand2 barrel shifter, bound to the top level
module bsh_checker (
    input  logic      clk,
    input  logic      rst_n,
    bsh_req_if.sink   req,
    bsh_rsp_if.source rsp
);

    logic [1:0] pending_reg;
    logic [1:0] pending_next;
    logic       req_fire;
    logic       rsp_fire;

    assign req_fire = req.valid && req.ready;
    assign rsp_fire = rsp.valid && rsp.ready;

    always_comb
    begin
        pending_next = pending_reg;
        if (req_fire && !rsp_fire)
        begin
            pending_next = pending_reg + 2'd1;
        end
        else if (!req_fire && rsp_fire)
        begin
            pending_next = pending_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_next;
        end
    end

    // a stalled result keeps its valid
    a_rsp_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && !rsp.ready |=> rsp.valid)
        else $error("result valid dropped while stalled");

    // a stalled result keeps its payload
    a_rsp_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && !rsp.ready |=> $stable(rsp.operand_value)
            && $stable(rsp.carry_write) && $stable(rsp.carry_value))
        else $error("result payload changed while stalled");

    // never more than two requests in flight
    a_capacity: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg != 2'd3)
        else $error("more requests in flight than registers");

    // no result without an accepted request behind it
    a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> pending_reg != 2'd0)
        else $error("result shown with no request pending");

    // both registers full and output stalled: no new request taken
    a_full_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg == 2'd2 && !rsp.ready |-> !req.ready)
        else $error("request accepted while full");

endmodule

bind operand2_barrel_shifter_top bsh_checker u_bsh_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .rsp   (rsp)
);

@@ tb/operand2_barrel_shifter_top_test.sv @@
// self-checking test of the operand2 barrel shifter top level
`timescale 1ns / 100ps

module operand2_barrel_shifter_top_test;

    localparam int unsigned RANDOM_REQUESTS = 450;
    localparam int unsigned QUIET_TAIL      = 60;
    localparam int unsigned LONG_HOLD       = 40;
    localparam int unsigned CYCLE_LIMIT     = 200000;

    typedef struct packed {
        logic                        imm_flag;
        logic                        set_flag;
        logic                        is_data_proc;
        logic [bsh_pkg::OP2_W-1:0]   op2_field;
        logic [bsh_pkg::DATA_W-1:0]  rm_value;
        logic [bsh_pkg::RS_W-1:0]    rs_low_byte;
        logic                        carry_in;
    } shift_req_t;

    typedef struct packed {
        logic [bsh_pkg::DATA_W-1:0]  operand_value;
        logic                        carry_write;
        logic                        carry_value;
    } shift_rsp_t;

    class operand_scoreboard;
        shift_rsp_t  expected_operands[$];
        int unsigned requests;
        int unsigned imm_requests;
        int unsigned rs_requests;
        int unsigned results;
        int unsigned errors;

        function automatic logic [bsh_pkg::DATA_W-1:0] rotate_right(
            logic [bsh_pkg::DATA_W-1:0] v, logic [bsh_pkg::AMT_W-1:0] n);
            logic [2*bsh_pkg::DATA_W-1:0] both;
            both = {v, v} >> n;
            return both[bsh_pkg::DATA_W-1:0];
        endfunction

        function automatic shift_rsp_t predict_operand(shift_req_t r);
            shift_rsp_t           p;
            logic                 by_reg;
            bsh_pkg::shift_type_t kind;
            int unsigned          amt;
            logic                 sign;
            p.operand_value = r.rm_value;
            p.carry_value   = r.carry_in;
            p.carry_write   = 1'b0;
            if (r.imm_flag)
            begin
                p.operand_value = rotate_right(
                    bsh_pkg::DATA_W'(r.op2_field[bsh_pkg::IMM_W-1:0]),
                    {r.op2_field[bsh_pkg::ROT_MSB:bsh_pkg::ROT_LSB], 1'b0});
            end
            else
            begin
                by_reg = r.op2_field[bsh_pkg::BY_REG_BIT];
                kind   = bsh_pkg::shift_type_t'(
                             r.op2_field[bsh_pkg::TYPE_MSB:bsh_pkg::TYPE_LSB]);
                amt    = by_reg ? int'(r.rs_low_byte)
                                : int'(r.op2_field[bsh_pkg::AMT_MSB:bsh_pkg::AMT_LSB]);
                sign   = r.rm_value[bsh_pkg::DATA_W-1];
                // a zero field for LSR and ASR encodes a full-word shift
                if (!by_reg && amt == 0
                    && (kind == bsh_pkg::SHIFT_LSR || kind == bsh_pkg::SHIFT_ASR))
                    amt = bsh_pkg::DATA_W;
                if (amt != 0)
                begin
                    case (kind)
                        bsh_pkg::SHIFT_LSL:
                        begin
                            if (amt < bsh_pkg::DATA_W)
                            begin
                                p.carry_value   = r.rm_value[bsh_pkg::DATA_W-amt];
                                p.operand_value = r.rm_value << amt;
                            end
                            else
                            begin
                                p.carry_value   = (amt == bsh_pkg::DATA_W) ? r.rm_value[0]
                                                                           : 1'b0;
                                p.operand_value = '0;
                            end
                        end
                        bsh_pkg::SHIFT_LSR:
                        begin
                            if (amt < bsh_pkg::DATA_W)
                            begin
                                p.carry_value   = r.rm_value[amt-1];
                                p.operand_value = r.rm_value >> amt;
                            end
                            else
                            begin
                                p.carry_value   = (amt == bsh_pkg::DATA_W) ? sign : 1'b0;
                                p.operand_value = '0;
                            end
                        end
                        bsh_pkg::SHIFT_ASR:
                        begin
                            if (amt < bsh_pkg::DATA_W)
                            begin
                                p.carry_value   = r.rm_value[amt-1];
                                p.operand_value = $signed(r.rm_value) >>> amt;
                            end
                            else
                            begin
                                p.carry_value   = sign;
                                p.operand_value = {bsh_pkg::DATA_W{sign}};
                            end
                        end
                        default:
                        begin
                            if (amt[bsh_pkg::AMT_W-1:0] == 0)
                                p.carry_value = sign;
                            else
                            begin
                                p.carry_value   = r.rm_value[amt[bsh_pkg::AMT_W-1:0]-1];
                                p.operand_value = rotate_right(r.rm_value,
                                                               amt[bsh_pkg::AMT_W-1:0]);
                            end
                        end
                    endcase
                end
                p.carry_write = r.set_flag & r.is_data_proc;
            end
            return p;
        endfunction

        function void note_request(shift_req_t r);
            requests++;
            if (r.imm_flag)
                imm_requests++;
            else if (r.op2_field[bsh_pkg::BY_REG_BIT])
                rs_requests++;
            expected_operands.push_back(predict_operand(r));
        endfunction

        function void check_result(shift_rsp_t actual);
            shift_rsp_t exp_rsp;
            results++;
            if (expected_operands.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result: operand %h carry_write %b carry %b",
                             actual.operand_value, actual.carry_write, actual.carry_value);
                return;
            end
            exp_rsp = expected_operands.pop_front();
            if (actual !== exp_rsp)
            begin
                errors++;
                if (errors <= 10)
                    $display("mismatch at result %0d: exp %h/%b/%b act %h/%b/%b",
                             results, exp_rsp.operand_value, exp_rsp.carry_write,
                             exp_rsp.carry_value, actual.operand_value,
                             actual.carry_write, actual.carry_value);
            end
        endfunction

        function int unsigned pending();
            return expected_operands.size();
        endfunction
    endclass

    logic clk;
    logic rst_n;
    bit   quiet_phase;
    bit   output_held;
    bit   long_hold_done;
    int unsigned hold_cycles;

    operand_scoreboard sb = new();

    bsh_req_if req_ch();
    bsh_rsp_if rsp_ch();

    operand2_barrel_shifter_top i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // request and result monitors sample at the edge, before this edge's updates
    always @(posedge clk)
    begin
        shift_req_t r;
        if (req_ch.valid && req_ch.ready)
        begin
            r.imm_flag     = req_ch.imm_flag;
            r.set_flag     = req_ch.set_flag;
            r.is_data_proc = req_ch.is_data_proc;
            r.op2_field    = req_ch.op2_field;
            r.rm_value     = req_ch.rm_value;
            r.rs_low_byte  = req_ch.rs_low_byte;
            r.carry_in     = req_ch.carry_in;
            sb.note_request(r);
        end
    end

    always @(posedge clk)
    begin
        shift_rsp_t a;
        if (rsp_ch.valid && rsp_ch.ready)
        begin
            a.operand_value = rsp_ch.operand_value;
            a.carry_write   = rsp_ch.carry_write;
            a.carry_value   = rsp_ch.carry_value;
            sb.check_result(a);
        end
    end

    // result side: random stall bursts, one long hold to back up the pipe
    initial
    begin
        rsp_ch.ready <= 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (!long_hold_done && sb.requests >= 120)
            begin
                rsp_ch.ready <= 1'b0;
                output_held  <= 1'b1;
                hold_cycles = 0;
                while (hold_cycles < LONG_HOLD)
                begin
                    @(posedge clk);
                    hold_cycles++;
                end
                output_held    <= 1'b0;
                long_hold_done = 1'b1;
            end
            else if (!quiet_phase && $urandom_range(0, 3) == 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge clk);
            end
            else
            begin
                rsp_ch.ready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge clk);
            end
        end
    end

    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("timeout after %0d cycles, %0d results outstanding", CYCLE_LIMIT, sb.pending());
        $display("Some tests failed");
        $finish;
    end

    task automatic send_request(input shift_req_t r);
        req_ch.valid        <= 1'b1;
        req_ch.imm_flag     <= r.imm_flag;
        req_ch.set_flag     <= r.set_flag;
        req_ch.is_data_proc <= r.is_data_proc;
        req_ch.op2_field    <= r.op2_field;
        req_ch.rm_value     <= r.rm_value;
        req_ch.rs_low_byte  <= r.rs_low_byte;
        req_ch.carry_in     <= r.carry_in;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
    endtask

    task automatic maybe_idle();
        if (!quiet_phase && !output_held && $urandom_range(0, 4) == 0)
        begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
    endtask

    function automatic shift_req_t imm_req(logic [3:0] rot, logic [bsh_pkg::IMM_W-1:0] imm8,
                                           logic cin, logic setf, logic dp);
        shift_req_t r;
        r.imm_flag     = 1'b1;
        r.set_flag     = setf;
        r.is_data_proc = dp;
        r.op2_field    = {rot, imm8};
        r.rm_value     = $urandom;
        r.rs_low_byte  = 8'($urandom);
        r.carry_in     = cin;
        return r;
    endfunction

    function automatic shift_req_t reg_req(bsh_pkg::shift_type_t kind,
                                           logic [bsh_pkg::AMT_W-1:0] amt5,
                                           logic by_reg, logic [bsh_pkg::DATA_W-1:0] rm,
                                           logic [bsh_pkg::RS_W-1:0] rs, logic cin,
                                           logic setf, logic dp);
        shift_req_t r;
        r.imm_flag     = 1'b0;
        r.set_flag     = setf;
        r.is_data_proc = dp;
        r.op2_field    = {amt5, kind, by_reg, 4'($urandom)};
        r.rm_value     = rm;
        r.rs_low_byte  = rs;
        r.carry_in     = cin;
        return r;
    endfunction

    initial
    begin
        shift_req_t                  r;
        shift_req_t                  directed[$];
        logic [bsh_pkg::DATA_W-1:0]  rm;
        logic [bsh_pkg::RS_W-1:0]    rs;
        logic [bsh_pkg::AMT_W-1:0]   amt5;
        int unsigned                 drain;

        rst_n               <= 1'b0;
        req_ch.valid        <= 1'b0;
        req_ch.imm_flag     <= 1'b0;
        req_ch.set_flag     <= 1'b0;
        req_ch.is_data_proc <= 1'b0;
        req_ch.op2_field    <= '0;
        req_ch.rm_value     <= '0;
        req_ch.rs_low_byte  <= '0;
        req_ch.carry_in     <= 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // immediate form never writes the carry
        directed.push_back(imm_req(4'd0,  8'hFF, 1'b1, 1'b1, 1'b1));
        directed.push_back(imm_req(4'd15, 8'h81, 1'b0, 1'b1, 1'b1));
        directed.push_back(imm_req(4'd1,  8'h00, 1'b1, 1'b0, 1'b0));
        // five-bit amount encodings
        directed.push_back(reg_req(bsh_pkg::SHIFT_LSL, 5'd0,  1'b0, 32'hDEADBEEF, 8'd0,
                                   1'b1, 1'b1, 1'b1));
        directed.push_back(reg_req(bsh_pkg::SHIFT_LSL, 5'd31, 1'b0, 32'h00000001, 8'd0,
                                   1'b0, 1'b1, 1'b1));
        directed.push_back(reg_req(bsh_pkg::SHIFT_LSL, 5'd1,  1'b0, 32'h80000000, 8'd0,
                                   1'b0, 1'b0, 1'b1));
        directed.push_back(reg_req(bsh_pkg::SHIFT_LSR, 5'd0,  1'b0, 32'h80000000, 8'd0,
                                   1'b0, 1'b1, 1'b0));
        directed.push_back(reg_req(bsh_pkg::SHIFT_LSR, 5'd1,  1'b0, 32'h00000001, 8'd0,
                                   1'b0, 1'b1, 1'b1));
        directed.push_back(reg_req(bsh_pkg::SHIFT_ASR, 5'd0,  1'b0, 32'h80000001, 8'd0,
                                   1'b0, 1'b1, 1'b1));
        directed.push_back(reg_req(bsh_pkg::SHIFT_ASR, 5'd0,  1'b0, 32'h7FFFFFFF, 8'd0,
                                   1'b1, 1'b1, 1'b1));
        directed.push_back(reg_req(bsh_pkg::SHIFT_ASR, 5'd31, 1'b0, 32'h80000000, 8'd0,
                                   1'b0, 1'b1, 1'b1));
        directed.push_back(reg_req(bsh_pkg::SHIFT_ROR, 5'd0,  1'b0, 32'h12345678, 8'd0,
                                   1'b1, 1'b1, 1'b1));
        directed.push_back(reg_req(bsh_pkg::SHIFT_ROR, 5'd31, 1'b0, 32'hFFFFFFFE, 8'd0,
                                   1'b0, 1'b1, 1'b1));
        // amounts taken from Rs, zero and beyond the word width
        directed.push_back(reg_req(bsh_pkg::SHIFT_LSL, 5'd0, 1'b1, 32'hA5A5A5A5, 8'd0,
                                   1'b1, 1'b1, 1'b1));
        directed.push_back(reg_req(bsh_pkg::SHIFT_ROR, 5'd0, 1'b1, 32'h5A5A5A5A, 8'd0,
                                   1'b0, 1'b1, 1'b1));
        directed.push_back(reg_req(bsh_pkg::SHIFT_LSL, 5'd0, 1'b1, 32'h00000001, 8'd32,
                                   1'b0, 1'b1, 1'b1));
        directed.push_back(reg_req(bsh_pkg::SHIFT_LSL, 5'd0, 1'b1, 32'hFFFFFFFF, 8'd33,
                                   1'b1, 1'b1, 1'b1));
        directed.push_back(reg_req(bsh_pkg::SHIFT_LSR, 5'd0, 1'b1, 32'h80000000, 8'd32,
                                   1'b0, 1'b1, 1'b1));
        directed.push_back(reg_req(bsh_pkg::SHIFT_LSR, 5'd0, 1'b1, 32'hFFFFFFFF, 8'd255,
                                   1'b1, 1'b1, 1'b1));
        directed.push_back(reg_req(bsh_pkg::SHIFT_ASR, 5'd0, 1'b1, 32'h80000000, 8'd32,
                                   1'b0, 1'b1, 1'b1));
        directed.push_back(reg_req(bsh_pkg::SHIFT_ASR, 5'd0, 1'b1, 32'h7FFFFFFF, 8'd200,
                                   1'b1, 1'b1, 1'b1));
        directed.push_back(reg_req(bsh_pkg::SHIFT_ROR, 5'd0, 1'b1, 32'h80000001, 8'd64,
                                   1'b0, 1'b1, 1'b1));
        directed.push_back(reg_req(bsh_pkg::SHIFT_ROR, 5'd0, 1'b1, 32'h00000003, 8'd33,
                                   1'b0, 1'b1, 1'b1));
        directed.push_back(reg_req(bsh_pkg::SHIFT_ROR, 5'd0, 1'b1, 32'h0000FFFF, 8'd31,
                                   1'b0, 1'b0, 1'b0));
        // bit 7 set alongside an Rs amount has no effect
        directed.push_back(reg_req(bsh_pkg::SHIFT_ASR, 5'd1, 1'b1, 32'hF0000000, 8'd5,
                                   1'b0, 1'b1, 1'b1));

        foreach (directed[i])
            send_request(directed[i]);

        for (int i = 0; i < RANDOM_REQUESTS; i++)
        begin
            if (i >= RANDOM_REQUESTS - QUIET_TAIL)
                quiet_phase = 1'b1;
            maybe_idle();
            case ($urandom_range(0, 7))
                0: rm = 32'h00000000;
                1: rm = 32'hFFFFFFFF;
                2: rm = 32'h80000000;
                default: rm = $urandom;
            endcase
            case ($urandom_range(0, 7))
                0: rs = 8'd0;
                1: rs = 8'd32;
                2: rs = 8'($urandom_range(33, 255));
                3: rs = 8'(32 * $urandom_range(2, 7));
                default: rs = 8'($urandom_range(1, 31));
            endcase
            case ($urandom_range(0, 4))
                0: amt5 = 5'd0;
                1: amt5 = 5'd31;
                default: amt5 = 5'($urandom);
            endcase
            if ($urandom_range(0, 3) == 0)
            begin
                r = imm_req(4'($urandom), 8'($urandom), 1'($urandom), 1'($urandom),
                            1'($urandom));
            end
            else
            begin
                r = reg_req(bsh_pkg::shift_type_t'($urandom_range(0, 3)), amt5,
                            1'($urandom), rm, rs, 1'($urandom), 1'($urandom),
                            1'($urandom));
            end
            send_request(r);
        end
        req_ch.valid <= 1'b0;

        while (sb.pending() != 0)
            @(posedge clk);
        drain = 0;
        while (drain < 4)
        begin
            @(posedge clk);
            drain++;
        end

        $display("checked %0d results for %0d requests: %0d immediate, %0d with Rs amount",
                 sb.results, sb.requests, sb.imm_requests, sb.rs_requests);
        $display("all four shift types, zero and full-word amounts, random stalls on both sides");
        if (sb.errors == 0 && sb.pending() == 0 && sb.results == sb.requests)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
